FILE: rtl/ypp_pkg.sv
package ypp_pkg;

    // Field and state widths.
    localparam int ANGLE_BITS = 24;
    localparam int SUM_BITS   = 48;
    localparam int GAIN_BITS  = 8;
    localparam int DRIVE_BITS = 11;

    // Widths of the intermediate terms.
    localparam int ERR_BITS    = ANGLE_BITS + 1;
    localparam int DIFF_BITS   = ANGLE_BITS + 2;
    localparam int PROD_P_BITS = ERR_BITS + GAIN_BITS + 1;
    localparam int PROD_D_BITS = DIFF_BITS + GAIN_BITS + 1;
    localparam int PD_BITS     = PROD_D_BITS + 1;
    localparam int PD200_BITS  = PD_BITS + 8;
    localparam int PROD_I_BITS = SUM_BITS + GAIN_BITS + 1;
    localparam int TOTAL_BITS  =
        ((PD200_BITS > PROD_I_BITS) ? PD200_BITS : PROD_I_BITS) + 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = GAIN_BITS;

    // Output scaling: divide by 200, shift right by 2, clamp to +-1000.
    localparam int I_DIVISOR      = 200;
    localparam int DIV_POW2_SHIFT = 3;
    localparam int DIV_ODD        = I_DIVISOR >> DIV_POW2_SHIFT;
    localparam int OUT_SHIFT      = 2;
    localparam int DRIVE_MAX      = 1000;

    // Totals at or beyond these bounds clamp the drive.
    localparam int TOTAL_HI = I_DIVISOR * (DRIVE_MAX << OUT_SHIFT);
    localparam int TOTAL_LO =
        -(I_DIVISOR * ((DRIVE_MAX << OUT_SHIFT) - ((1 << OUT_SHIFT) - 1)));

    // Reciprocal division of the in-range magnitude by the odd factor.
    localparam int MAG_BITS    = 20;
    localparam int Y_BITS      = MAG_BITS - DIV_POW2_SHIFT;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_BITS  = 18;
    localparam int RECIP_ODD   = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
    localparam int PRODQ_BITS  = Y_BITS + RECIP_BITS;
    localparam int Q_BITS      = 12;
    localparam int VQ_BITS     = Q_BITS + 1;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] p;
        logic [GAIN_BITS-1:0] i;
        logic [GAIN_BITS-1:0] d;
    } gains_t;

    // Integral stage to gain stage.
    typedef struct packed {
        logic                        valid;
        logic signed [ERR_BITS-1:0]  err;
        logic signed [DIFF_BITS-1:0] diff;
        logic signed [SUM_BITS-1:0]  sum;
    } integ_bus_t;

    // Gain stage to output scaling.
    typedef struct packed {
        logic                         valid;
        logic signed [TOTAL_BITS-1:0] total;
    } total_bus_t;

endpackage

FILE: rtl/ypp_if.sv
// Angle request channel.
interface ypp_angle_if;
    import ypp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_BITS-1:0]  measured_angle;
    logic signed [ANGLE_BITS-1:0]  target_angle;

    modport source (output valid, output measured_angle, output target_angle, input ready);
    modport sink (input valid, input measured_angle, input target_angle, output ready);
endinterface

// Drive request channel.
interface ypp_drive_if;
    import ypp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [DRIVE_BITS-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

FILE: rtl/ypp_integ.sv
module ypp_integ (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ypp_pkg::ANGLE_BITS-1:0] measured_angle,
    input  logic signed [ypp_pkg::ANGLE_BITS-1:0] target_angle,
    output ypp_pkg::integ_bus_t                 out_bus,
    input  logic                                out_ready
);
    import ypp_pkg::*;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic                        err_valid_reg;
    logic signed [ERR_BITS-1:0]  err_reg;
    logic signed [ERR_BITS-1:0]  err_next;
    logic                        integ_valid_reg;
    logic signed [ERR_BITS-1:0]  last_err_reg;
    logic signed [DIFF_BITS-1:0] diff_reg;
    logic signed [DIFF_BITS-1:0] diff_next;
    logic signed [SUM_BITS-1:0]  sum_reg;
    logic signed [SUM_BITS-1:0]  sum_next;
    logic signed [SUM_BITS:0]    sum_wide;
    logic                        err_ready;
    logic                        integ_ready;
    logic                        err_load;
    logic                        integ_load;

    // A stage takes a new request when it is empty or its content moves on.
    assign integ_ready = !integ_valid_reg || out_ready;
    assign err_ready   = !err_valid_reg || integ_ready;
    assign in_ready    = err_ready;
    assign err_load    = err_ready && in_valid;
    assign integ_load  = integ_ready && err_valid_reg;

    // Angle error, one bit wider than the angles.
    assign err_next = ERR_BITS'(measured_angle) - ERR_BITS'(target_angle);

    // Saturating integral: a sum beyond the signed range clamps to the limit on that side.
    always_comb
    begin
        sum_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(err_reg);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    // Change in error since the previous request.
    assign diff_next = DIFF_BITS'(err_reg) - DIFF_BITS'(last_err_reg);

    // Stage valid flags and the loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg   <= 1'b0;
            integ_valid_reg <= 1'b0;
            sum_reg         <= '0;
            last_err_reg    <= '0;
        end
        else
        begin
            if (err_ready)
            begin
                err_valid_reg <= in_valid;
            end
            if (integ_ready)
            begin
                integ_valid_reg <= err_valid_reg;
            end
            if (integ_load)
            begin
                sum_reg      <= sum_next;
                last_err_reg <= err_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (err_load)
        begin
            err_reg <= err_next;
        end
        if (integ_load)
        begin
            diff_reg <= diff_next;
        end
    end

    assign out_bus.valid = integ_valid_reg;
    assign out_bus.err   = last_err_reg;
    assign out_bus.diff  = diff_reg;
    assign out_bus.sum   = sum_reg;

endmodule

FILE: rtl/ypp_gain_mul.sv
module ypp_gain_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  ypp_pkg::gains_t     gains,
    input  ypp_pkg::integ_bus_t in_bus,
    output logic                in_ready,
    output ypp_pkg::total_bus_t out_bus,
    input  logic                out_ready
);
    import ypp_pkg::*;

    logic                          mul_valid_reg;
    logic signed [PROD_P_BITS-1:0] prod_p_reg;
    logic signed [PROD_D_BITS-1:0] prod_d_reg;
    logic signed [PROD_I_BITS-1:0] prod_i_reg;
    logic signed [PROD_P_BITS-1:0] prod_p_next;
    logic signed [PROD_D_BITS-1:0] prod_d_next;
    logic signed [PROD_I_BITS-1:0] prod_i_next;
    logic                          pd_valid_reg;
    logic signed [PD_BITS-1:0]     pd_sum;
    logic signed [PD200_BITS-1:0]  pd200_reg;
    logic signed [PD200_BITS-1:0]  pd200_next;
    logic signed [PROD_I_BITS-1:0] prod_i_hold_reg;
    logic                          tot_valid_reg;
    logic signed [TOTAL_BITS-1:0]  total_reg;
    logic signed [TOTAL_BITS-1:0]  total_next;
    logic                          mul_ready;
    logic                          pd_ready;
    logic                          tot_ready;

    // Backpressure chain through the three stages.
    assign tot_ready = !tot_valid_reg || out_ready;
    assign pd_ready  = !pd_valid_reg || tot_ready;
    assign mul_ready = !mul_valid_reg || pd_ready;
    assign in_ready  = mul_ready;

    // Gain products; the gains are unsigned.
    assign prod_p_next = in_bus.err * $signed({1'b0, gains.p});
    assign prod_d_next = in_bus.diff * $signed({1'b0, gains.d});
    assign prod_i_next = in_bus.sum * $signed({1'b0, gains.i});

    // Proportional and derivative terms scaled up to the integral divisor.
    assign pd_sum     = PD_BITS'(prod_p_reg) + PD_BITS'(prod_d_reg);
    assign pd200_next = PD200_BITS'(pd_sum) * PD200_BITS'(I_DIVISOR);

    // Whole control value times the divisor.
    assign total_next = TOTAL_BITS'(pd200_reg) + TOTAL_BITS'(prod_i_hold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            pd_valid_reg  <= 1'b0;
            tot_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                mul_valid_reg <= in_bus.valid;
            end
            if (pd_ready)
            begin
                pd_valid_reg <= mul_valid_reg;
            end
            if (tot_ready)
            begin
                tot_valid_reg <= pd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && in_bus.valid)
        begin
            prod_p_reg <= prod_p_next;
            prod_d_reg <= prod_d_next;
            prod_i_reg <= prod_i_next;
        end
        if (pd_ready && mul_valid_reg)
        begin
            pd200_reg       <= pd200_next;
            prod_i_hold_reg <= prod_i_reg;
        end
        if (tot_ready && pd_valid_reg)
        begin
            total_reg <= total_next;
        end
    end

    assign out_bus.valid = tot_valid_reg;
    assign out_bus.total = total_reg;

endmodule

FILE: rtl/ypp_out_scale.sv
module ypp_out_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ypp_pkg::total_bus_t                  in_bus,
    output logic                                 in_ready,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ypp_pkg::DRIVE_BITS-1:0] drive
);
    import ypp_pkg::*;

    localparam logic signed [TOTAL_BITS-1:0] TOT_HI = TOTAL_BITS'(TOTAL_HI);
    localparam logic signed [TOTAL_BITS-1:0] TOT_LO = TOTAL_BITS'(TOTAL_LO);
    localparam logic [RECIP_BITS-1:0]        RECIP  = RECIP_BITS'(RECIP_ODD);

    logic                         lim_valid_reg;
    logic                         hi_reg;
    logic                         lo_reg;
    logic                         neg_reg;
    logic [Y_BITS-1:0]            y_reg;
    logic [TOTAL_BITS-1:0]        mag;
    logic                         div_valid_reg;
    logic                         hi_div_reg;
    logic                         lo_div_reg;
    logic                         neg_div_reg;
    logic [Q_BITS-1:0]            q_reg;
    logic [PRODQ_BITS-1:0]        prod_q;
    logic signed [VQ_BITS-1:0]    q_signed;
    logic signed [VQ_BITS-1:0]    vq;
    logic signed [VQ_BITS-1:0]    vq_shift;
    logic signed [DRIVE_BITS-1:0] drive_next;
    logic                         out_valid_reg;
    logic signed [DRIVE_BITS-1:0] drive_reg;
    logic                         lim_ready;
    logic                         div_ready;
    logic                         out_stage_ready;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign div_ready       = !div_valid_reg || out_stage_ready;
    assign lim_ready       = !lim_valid_reg || div_ready;
    assign in_ready        = lim_ready;

    // Magnitude of the total; only its low bits matter when no clamp applies.
    assign mag = in_bus.total[TOTAL_BITS-1] ? TOTAL_BITS'(-in_bus.total)
                                            : TOTAL_BITS'(in_bus.total);

    // Division by the odd factor through a scaled reciprocal.
    assign prod_q = PRODQ_BITS'(y_reg) * PRODQ_BITS'(RECIP);

    // Truncated quotient, arithmetic shift, then the clamp.
    always_comb
    begin
        q_signed = $signed({1'b0, q_reg});
        vq       = neg_div_reg ? -q_signed : q_signed;
        vq_shift = vq >>> OUT_SHIFT;
        if (hi_div_reg)
        begin
            drive_next = DRIVE_BITS'(DRIVE_MAX);
        end
        else if (lo_div_reg)
        begin
            drive_next = DRIVE_BITS'(-DRIVE_MAX);
        end
        else
        begin
            drive_next = vq_shift[DRIVE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (lim_ready)
            begin
                lim_valid_reg <= in_bus.valid;
            end
            if (div_ready)
            begin
                div_valid_reg <= lim_valid_reg;
            end
            if (out_stage_ready)
            begin
                out_valid_reg <= div_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lim_ready && in_bus.valid)
        begin
            hi_reg  <= (in_bus.total >= TOT_HI);
            lo_reg  <= (in_bus.total <= TOT_LO);
            neg_reg <= in_bus.total[TOTAL_BITS-1];
            y_reg   <= mag[MAG_BITS-1:DIV_POW2_SHIFT];
        end
        if (div_ready && lim_valid_reg)
        begin
            hi_div_reg  <= hi_reg;
            lo_div_reg  <= lo_reg;
            neg_div_reg <= neg_reg;
            q_reg       <= prod_q[RECIP_SHIFT +: Q_BITS];
        end
        if (out_stage_ready && div_valid_reg)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

FILE: rtl/yaw_pid_pwm.sv
// Channel   Role   Fields                              Accepted when
// angles    sink   measured_angle, target_angle        valid and ready high at clk
// motor     source drive                               valid and ready high at clk
// cfg       write  cfg_index (0 gain_p, 1 i, 2 d)      cfg_wr_en high at clk
//
// A request passes through the eight pipeline stages (error, integral, gain products,
// term sum, total, clamp test, reciprocal multiply, output) to the output register;
// one request can enter every cycle unless a stalled output has backed the pipeline up.
// Reset clears the gains, the integral sum, the previous error and all stage flags.
// A stalled result holds in the output register while earlier stages keep filling.
module yaw_pid_pwm (
    input  logic                               clk,
    input  logic                               rst_n,
    ypp_angle_if.sink                          angles,
    ypp_drive_if.source                        motor,
    input  logic                               cfg_wr_en,
    input  ypp_pkg::cfg_index_t                cfg_index,
    input  logic [ypp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ypp_pkg::*;

    gains_t     gains_reg;
    integ_bus_t integ_bus;
    total_bus_t total_bus;
    logic       integ_ready;
    logic       total_ready;

    // Gain registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gains_reg.p <= cfg_data;
                REG_GAIN_I: gains_reg.i <= cfg_data;
                REG_GAIN_D: gains_reg.d <= cfg_data;
                default:    gains_reg   <= gains_reg;
            endcase
        end
    end

    // Error, integral and derivative.
    ypp_integ u_integ (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (angles.valid),
        .in_ready       (angles.ready),
        .measured_angle (angles.measured_angle),
        .target_angle   (angles.target_angle),
        .out_bus        (integ_bus),
        .out_ready      (integ_ready)
    );

    // Gain products and the combined total.
    ypp_gain_mul u_gain_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gains_reg),
        .in_bus    (integ_bus),
        .in_ready  (integ_ready),
        .out_bus   (total_bus),
        .out_ready (total_ready)
    );

    // Divide, shift, clamp and the output register.
    ypp_out_scale u_out_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bus    (total_bus),
        .in_ready  (total_ready),
        .out_valid (motor.valid),
        .out_ready (motor.ready),
        .drive     (motor.drive)
    );

endmodule

FILE: rtl/ypp_checker.sv
module ypp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                angles_valid,
    input logic                                angles_ready,
    input logic                                motor_valid,
    input logic                                motor_ready,
    input logic signed [ypp_pkg::DRIVE_BITS-1:0] drive
);
    import ypp_pkg::*;

    // The drive never leaves the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid |-> (drive <= DRIVE_BITS'(DRIVE_MAX)) && (drive >= DRIVE_BITS'(-DRIVE_MAX)))
        else $error("drive outside clamp range");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid && !motor_ready |=> motor_valid && $stable(drive))
        else $error("stalled drive request changed");

    // No result is shown right after reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !motor_valid)
        else $error("result valid right after reset");

    // A result on offer always carries a fully known drive value.
    assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid |-> !$isunknown(drive))
        else $error("drive unknown while valid");

endmodule

bind yaw_pid_pwm ypp_checker u_ypp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .angles_valid (angles.valid),
    .angles_ready (angles.ready),
    .motor_valid  (motor.valid),
    .motor_ready  (motor.ready),
    .drive        (motor.drive)
);
